### design/cfc_pkg.sv
package cfc_pkg;

    // Default sizes
    localparam int CFC_MAX_TAPS    = 63;
    localparam int CFC_SAMPLE_BITS = 16;

    // Fixed field widths
    localparam int COEF_W   = 16;
    localparam int TAPCNT_W = 6;
    localparam int FRAC_W   = 15;

    // Request modes
    localparam logic MODE_TAP    = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PUSH  = 5'b00010,
        S_MAC   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    // One product term moving down the read / multiply path
    typedef struct packed {
        logic vld;       // term slot is live
        logic contrib;   // term contributes (otherwise counts as zero)
    } t_term;

endpackage

### design/cfc_store.sv
module cfc_store import cfc_pkg::*; #(
    parameter int MAX_TAPS    = CFC_MAX_TAPS,
    parameter int SAMPLE_BITS = CFC_SAMPLE_BITS,
    parameter int AW          = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // kernel tap load
    input  logic                          i_tap_we,
    input  logic [AW-1:0]                 i_tap_waddr,
    input  logic signed [COEF_W-1:0]      i_tap_wdata,
    // window push
    input  logic                          i_win_we,
    input  logic [AW-1:0]                 i_win_waddr,
    input  logic signed [SAMPLE_BITS-1:0] i_win_wdata,
    // term read
    input  t_term                         i_rd_req,
    input  logic [AW-1:0]                 i_tap_raddr,
    input  logic [AW-1:0]                 i_win_raddr,
    output t_term                         o_rd,
    output logic signed [COEF_W-1:0]      o_tap,
    output logic signed [SAMPLE_BITS-1:0] o_win
);

    logic signed [COEF_W-1:0]      r_tap_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_win_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]           r_tap_vld;
    t_term                         r_rd;
    logic signed [COEF_W-1:0]      r_tap_q;
    logic signed [SAMPLE_BITS-1:0] r_win_q;

    // Kernel memory; unloaded taps read as zero through the valid bits
    always_ff @(posedge i_clk) begin
        if (i_tap_we) begin
            r_tap_mem[i_tap_waddr] <= i_tap_wdata;
        end
        r_tap_q <= r_tap_mem[i_tap_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_vld <= '0;
        end else if (i_tap_we) begin
            r_tap_vld[i_tap_waddr] <= 1'b1;
        end
    end

    // Circular sample window; fill count in the sequencer masks stale entries
    always_ff @(posedge i_clk) begin
        if (i_win_we) begin
            r_win_mem[i_win_waddr] <= i_win_wdata;
        end
        r_win_q <= r_win_mem[i_win_raddr];
    end

    // Term control follows the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
        end else begin
            r_rd.vld     <= i_rd_req.vld;
            r_rd.contrib <= i_rd_req.vld & i_rd_req.contrib & r_tap_vld[i_tap_raddr];
        end
    end

    assign o_rd  = r_rd;
    assign o_tap = r_tap_q;
    assign o_win = r_win_q;

endmodule

### design/cfc_mac.sv
module cfc_mac import cfc_pkg::*; #(
    parameter int SAMPLE_BITS = CFC_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clr,
    input  t_term                         i_rd,
    input  logic signed [COEF_W-1:0]      i_tap,
    input  logic signed [SAMPLE_BITS-1:0] i_win,
    output logic                          o_busy,
    output logic signed [SAMPLE_BITS-1:0] o_filtered,
    output logic                          o_saturated
);

    localparam int PW    = COEF_W + SAMPLE_BITS;
    localparam int ACC_W = PW + TAPCNT_W;
    localparam int QW    = ACC_W - FRAC_W;

    localparam logic signed [QW-1:0] SAT_HI =
        {{(QW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [QW-1:0] SAT_LO = ~SAT_HI;

    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    r_prod;
    logic                    r_prod_vld;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [QW-1:0]    quo;

    assign prod = i_tap * i_win;

    // Product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_rd.vld;
        end
        r_prod <= i_rd.contrib ? prod : '0;
    end

    // Accumulator
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_busy = i_rd.vld | r_prod_vld;

    // Floor shift out of Q1.15, then clip to the sample range
    assign quo = QW'(r_acc >>> FRAC_W);

    always_comb begin
        if (quo > SAT_HI) begin
            o_filtered  = SAT_HI[SAMPLE_BITS-1:0];
            o_saturated = 1'b1;
        end else if (quo < SAT_LO) begin
            o_filtered  = SAT_LO[SAMPLE_BITS-1:0];
            o_saturated = 1'b1;
        end else begin
            o_filtered  = quo[SAMPLE_BITS-1:0];
            o_saturated = 1'b0;
        end
    end

endmodule

### design/centered_fir_convolution_top.sv
// Same-size centered FIR (kernel not flipped) with one shared multiply-accumulate.
// A mode-0 request loads one kernel tap and does not stall. A mode-1 request
// pushes one sample; with nh = tap_count (clamped to MAX_TAPS) and c = nh/2,
// output k leaves once sample k+c is in. Each output is built in order: the
// push, then nh taps issued one tap per cycle to the multiplier through the
// single read port of each memory, then a drain of the read, product and
// accumulate stages, then the load of the output register; with a zero tap
// count there is no issue step. A sample that yields no output yet ends at
// its push unless it is marked last. The sample marked last flushes c zeros,
// each handled like a pushed sample; its final output carries end_of_signal
// and the window then starts empty.
// The input is stalled while a sample is in work. A result waits in the
// output register while the next request is accepted; a stalled result holds
// off the next output load until it is taken. There is no clearing pass
// after reset: unloaded taps read as zero through per-tap valid bits, and
// window entries older than the fill count read as zero.
module centered_fir_convolution_top import cfc_pkg::*; #(
    parameter int MAX_TAPS    = CFC_MAX_TAPS,
    parameter int SAMPLE_BITS = CFC_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [TAPCNT_W-1:0]           i_cfg_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [TAPCNT_W-1:0]           i_tap_index,
    input  logic signed [COEF_W-1:0]      i_coefficient,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_filtered,
    output logic                          o_saturated,
    output logic                          o_end_of_signal
);

    localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int SEEN_W = $clog2(MAX_TAPS + 1);
    localparam int CW     = ((AW > TAPCNT_W) ? AW : TAPCNT_W) + 2;
    localparam int C_W    = TAPCNT_W - 1;

    t_state                        r_state, n_state;
    logic [TAPCNT_W-1:0]           r_tapcnt;
    logic [TAPCNT_W-1:0]           r_nh, n_nh;
    logic [C_W-1:0]                r_c, n_c;
    logic [C_W-1:0]                r_left, n_left;
    logic                          r_last, n_last;
    logic signed [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [AW-1:0]                 r_ptr, n_ptr;
    logic [SEEN_W-1:0]             r_seen, n_seen;
    logic [TAPCNT_W-1:0]           r_j, n_j;

    logic                          r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_filtered;
    logic                          r_sat;
    logic                          r_eos;

    logic                          in_acc;
    logic                          out_take;
    logic                          out_load;
    logic                          tap_we;
    logic                          win_we;
    logic                          acc_clr;
    t_term                         rd_req;
    t_term                         rd;
    logic [AW-1:0]                 ptr_next;
    logic [SEEN_W-1:0]             seen_next;
    logic [TAPCNT_W-1:0]           idx;
    logic [CW-1:0]                 idx_w;
    logic [CW-1:0]                 ptr_w;
    logic [CW-1:0]                 win_addr_w;
    logic [TAPCNT_W-1:0]           nh_clamp;
    logic signed [COEF_W-1:0]      tap_q;
    logic signed [SAMPLE_BITS-1:0] win_q;
    logic                          mac_busy;
    logic signed [SAMPLE_BITS-1:0] mac_filtered;
    logic                          mac_sat;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_take = r_out_vld && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Kernel loads happen straight from the request
    assign tap_we = in_acc && (i_mode == MODE_TAP) &&
                    (CW'(i_tap_index) < CW'(MAX_TAPS));

    assign nh_clamp = (CW'(r_tapcnt) > CW'(MAX_TAPS)) ? TAPCNT_W'(MAX_TAPS) : r_tapcnt;

    // Window pointer and fill count after a push
    assign ptr_next  = (r_ptr == AW'(MAX_TAPS - 1)) ? '0 : r_ptr + 1'b1;
    assign seen_next = (r_seen == SEEN_W'(MAX_TAPS)) ? r_seen : r_seen + 1'b1;

    // Term j reads window entry 2c - j counted back from the newest sample
    assign idx   = {r_c, 1'b0} - r_j;
    assign idx_w = CW'(idx);
    assign ptr_w = CW'(r_ptr);
    assign win_addr_w = (ptr_w >= idx_w) ? ptr_w - idx_w : ptr_w + CW'(MAX_TAPS) - idx_w;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_nh     = r_nh;
        n_c      = r_c;
        n_left   = r_left;
        n_last   = r_last;
        n_sample = r_sample;
        n_ptr    = r_ptr;
        n_seen   = r_seen;
        n_j      = r_j;
        win_we   = 1'b0;
        acc_clr  = 1'b0;
        out_load = 1'b0;
        rd_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_mode == MODE_SAMPLE)) begin
                    n_nh     = nh_clamp;
                    n_c      = nh_clamp[TAPCNT_W-1:1];
                    n_left   = i_last ? nh_clamp[TAPCNT_W-1:1] : '0;
                    n_last   = i_last;
                    n_sample = i_sample;
                    n_state  = S_PUSH;
                end
            end
            S_PUSH: begin
                win_we   = 1'b1;
                n_ptr    = ptr_next;
                n_seen   = seen_next;
                n_sample = '0;
                if (CW'(seen_next) > CW'(r_c)) begin
                    acc_clr = 1'b1;
                    n_j     = '0;
                    n_state = (r_nh == '0) ? S_DRAIN : S_MAC;
                end else if (r_left != '0) begin
                    n_left = r_left - 1'b1;
                end else begin
                    if (r_last) begin
                        n_seen = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_MAC: begin
                rd_req.vld     = 1'b1;
                rd_req.contrib = (idx_w < CW'(MAX_TAPS)) && (idx_w < CW'(r_seen));
                n_j            = r_j + 1'b1;
                if (r_j == r_nh - 1'b1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!mac_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_vld || !i_out_stall) begin
                    out_load = 1'b1;
                    if (r_left != '0) begin
                        n_left  = r_left - 1'b1;
                        n_state = S_PUSH;
                    end else begin
                        if (r_last) begin
                            n_seen = '0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_seen  <= '0;
            r_left  <= '0;
            r_last  <= 1'b0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_seen  <= n_seen;
            r_left  <= n_left;
            r_last  <= n_last;
            r_j     <= n_j;
        end
        r_nh     <= n_nh;
        r_c      <= n_c;
        r_sample <= n_sample;
    end

    // Tap count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tapcnt <= TAPCNT_W'(1);
        end else if (i_cfg_we) begin
            r_tapcnt <= i_cfg_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (out_take) begin
            r_out_vld <= 1'b0;
        end
        if (out_load) begin
            r_filtered <= mac_filtered;
            r_sat      <= mac_sat;
            r_eos      <= r_last && (r_left == '0);
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_filtered      = r_filtered;
    assign o_saturated     = r_sat;
    assign o_end_of_signal = r_eos;

    cfc_store #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tap_we    (tap_we),
        .i_tap_waddr (AW'(i_tap_index)),
        .i_tap_wdata (i_coefficient),
        .i_win_we    (win_we),
        .i_win_waddr (ptr_next),
        .i_win_wdata (r_sample),
        .i_rd_req    (rd_req),
        .i_tap_raddr (AW'(r_j)),
        .i_win_raddr (AW'(win_addr_w)),
        .o_rd        (rd),
        .o_tap       (tap_q),
        .o_win       (win_q)
    );

    cfc_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (acc_clr),
        .i_rd        (rd),
        .i_tap       (tap_q),
        .i_win       (win_q),
        .o_busy      (mac_busy),
        .o_filtered  (mac_filtered),
        .o_saturated (mac_sat)
    );

endmodule

### design/cfc_checker.sv
module cfc_checker import cfc_pkg::*; #(
    parameter int SAMPLE_BITS = CFC_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [SAMPLE_BITS-1:0] o_filtered,
    input  logic                          o_saturated,
    input  logic                          o_end_of_signal
);

    localparam logic [SAMPLE_BITS-1:0] RAIL_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] RAIL_LO = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // Reset leaves both channels quiet
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("channels not idle after reset");

    // A tap-load request never holds off the next request
    a_tap_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_mode == MODE_TAP) |=> !o_in_stall)
        else $error("stall raised after tap load");

    // A sample request occupies the block in the next cycle
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_mode == MODE_SAMPLE) |=> o_in_stall)
        else $error("no stall after sample request");

    // Clipped result sits on a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_filtered == RAIL_HI) || (o_filtered == RAIL_LO))
        else $error("saturated result off the rails");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_filtered) && $stable(o_saturated)
            && $stable(o_end_of_signal))
        else $error("stalled result changed");

endmodule

bind centered_fir_convolution_top cfc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_mode          (i_mode),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_filtered      (o_filtered),
    .o_saturated     (o_saturated),
    .o_end_of_signal (o_end_of_signal)
);

### bench/tb_centered_fir_convolution_top.sv
`timescale 1ns / 100ps

module tb_centered_fir_convolution_top import cfc_pkg::*;;

    localparam int NTAPS = CFC_MAX_TAPS;
    localparam int SB    = CFC_SAMPLE_BITS;
    // enough for the longest output with margin
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic                   mode;
        logic [TAPCNT_W-1:0]    tap_index;
        logic signed [COEF_W-1:0] coefficient;
        logic signed [SB-1:0]   sample;
        logic                   last;
    } t_fir_req;

    typedef struct {
        logic signed [SB-1:0] filtered;
        logic                 saturated;
        logic                 end_of_signal;
    } t_fir_out;

    // DUT connections, inputs known from time zero
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [TAPCNT_W-1:0]      i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_mode = MODE_TAP;
    logic [TAPCNT_W-1:0]      i_tap_index = '0;
    logic signed [COEF_W-1:0] i_coefficient = '0;
    logic signed [SB-1:0]     i_sample = '0;
    logic                     i_last = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [SB-1:0]     o_filtered;
    logic                     o_saturated;
    logic                     o_end_of_signal;

    // request backlog, expected outputs, bookkeeping
    t_fir_req request_backlog[$];
    t_fir_out expected_outputs[$];
    int       reqs_queued = 0;
    int       reqs_accepted = 0;
    int       mismatches = 0;
    bit       quiet_tail = 1'b0;
    logic     req_accepted = 1'b0;
    int       send_gap = 0;
    int       stall_left = 0;
    t_fir_req taken;
    t_fir_out want;

    // shadow of the convolver state
    logic signed [COEF_W-1:0] kern [NTAPS];
    logic signed [SB-1:0]     win [NTAPS];
    int                       win_fill = 0;
    int                       taps_in_use = 1;

    centered_fir_convolution_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_tap_index     (i_tap_index),
        .i_coefficient   (i_coefficient),
        .i_sample        (i_sample),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_filtered      (o_filtered),
        .o_saturated     (o_saturated),
        .o_end_of_signal (o_end_of_signal)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic void shift_in(logic signed [SB-1:0] s);
        for (int i = NTAPS - 1; i > 0; i--)
            win[i] = win[i-1];
        win[0] = s;
        if (win_fill < NTAPS)
            win_fill++;
    endfunction

    // kernel (not flipped) against the window, centered on tap c
    function automatic t_fir_out centered_dot(int nh, int c, bit end_flag);
        longint   acc;
        longint   q;
        longint   hi;
        int       idx;
        t_fir_out r;
        acc = 0;
        hi  = (longint'(1) <<< (SB - 1)) - 1;
        for (int j = 0; j < nh; j++) begin
            idx = 2 * c - j;
            if (idx >= 0 && idx < NTAPS)
                acc += longint'(kern[j]) * longint'(win[idx]);
        end
        q = acc >>> FRAC_W;   // floor toward minus infinity
        r.saturated = 1'b0;
        if (q > hi) begin
            q = hi;
            r.saturated = 1'b1;
        end else if (q < -hi - 1) begin
            q = -hi - 1;
            r.saturated = 1'b1;
        end
        r.filtered      = q[SB-1:0];
        r.end_of_signal = end_flag;
        return r;
    endfunction

    // apply one accepted request, queue the outputs it releases
    function automatic void convolve_request(t_fir_req r);
        int               nh;
        int               c;
        int               pushes;
        logic signed [SB-1:0] s;
        if (r.mode == MODE_TAP) begin
            if (r.tap_index < NTAPS)
                kern[r.tap_index] = r.coefficient;
            return;
        end
        nh     = (taps_in_use > NTAPS) ? NTAPS : taps_in_use;
        c      = nh / 2;
        pushes = r.last ? c + 1 : 1;
        for (int i = 0; i < pushes; i++) begin
            s = (i == 0) ? r.sample : '0;
            shift_in(s);
            if (win_fill > c)
                expected_outputs.push_back(centered_dot(nh, c, r.last && (i + 1 == pushes)));
        end
        // flush done: window starts empty for the next signal
        if (r.last) begin
            for (int i = 0; i < NTAPS; i++)
                win[i] = '0;
            win_fill = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_fir_req tap_req(int idx, logic signed [COEF_W-1:0] coef, bit lst);
        t_fir_req r;
        r.mode        = MODE_TAP;
        r.tap_index   = idx[TAPCNT_W-1:0];
        r.coefficient = coef;
        r.sample      = SB'($urandom());
        r.last        = lst;
        return r;
    endfunction

    function automatic t_fir_req sample_req(logic signed [SB-1:0] s, bit lst);
        t_fir_req r;
        r.mode        = MODE_SAMPLE;
        r.tap_index   = TAPCNT_W'($urandom_range(0, 63));
        r.coefficient = COEF_W'($urandom());
        r.sample      = s;
        r.last        = lst;
        return r;
    endfunction

    // random 16-bit word, extremes favored
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic void enqueue(t_fir_req r);
        request_backlog.push_back(r);
        reqs_queued++;
    endfunction

    // well-formed signals with random content, some noise in between
    function automatic void queue_random_phase(int n_items, int nh);
        int added;
        int len;
        added = 0;
        while (added < n_items) begin
            if ($urandom_range(0, 9) < 2) begin
                // stray tap write, any index, last flag random
                enqueue(tap_req($urandom_range(0, 63), rand_word(), 1'($urandom_range(0, 1))));
                added++;
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    enqueue(tap_req($urandom_range(0, (nh > 0) ? nh - 1 : 0), rand_word(), 1'b0));
                    added++;
                end
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++) begin
                    // occasional kernel update in mid-signal
                    if (k > 0 && $urandom_range(0, 7) == 0) begin
                        enqueue(tap_req($urandom_range(0, 62), rand_word(), 1'b0));
                        added++;
                    end
                    enqueue(sample_req(rand_word(), k == len - 1));
                    added++;
                end
            end
        end
    endfunction

    // wait until every request is in and every output is out, then let
    // any output-less request finish its internal work
    task automatic settle();
        while (reqs_accepted != reqs_queued || expected_outputs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_tap_count(int v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[TAPCNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        taps_in_use = v;
    endtask

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_in_valid && !req_accepted) begin
            // stalled: hold the request
        end else begin
            if (req_accepted && !quiet_tail && $urandom_range(0, 5) == 0)
                send_gap = $urandom_range(1, 16);
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
                taken = request_backlog.pop_front();
                i_mode        <= taken.mode;
                i_tap_index   <= taken.tap_index;
                i_coefficient <= taken.coefficient;
                i_sample      <= taken.sample;
                i_last        <= taken.last;
                i_in_valid    <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result-side stall bursts
    always @(negedge i_clk) begin
        if (quiet_tail || !i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on each accepted request, check each output
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_fir_req got;
        if (!i_rst_n) begin
            req_accepted <= 1'b0;
        end else begin
            req_accepted <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                got.mode        = i_mode;
                got.tap_index   = i_tap_index;
                got.coefficient = i_coefficient;
                got.sample      = i_sample;
                got.last        = i_last;
                convolve_request(got);
                reqs_accepted++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_outputs.size() == 0) begin
                    $error("unexpected output: filtered=%0d saturated=%0b end_of_signal=%0b",
                           o_filtered, o_saturated, o_end_of_signal);
                    mismatches++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (o_filtered !== want.filtered) begin
                        $error("filtered: expected %0d, actual %0d", want.filtered, o_filtered);
                        mismatches++;
                    end
                    if (o_saturated !== want.saturated) begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, o_saturated);
                        mismatches++;
                    end
                    if (o_end_of_signal !== want.end_of_signal) begin
                        $error("end_of_signal: expected %0b, actual %0b",
                               want.end_of_signal, o_end_of_signal);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        for (int i = 0; i < NTAPS; i++) begin
            kern[i] = '0;
            win[i]  = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: three taps at the extremes, saturating signal
        set_tap_count(3);
        enqueue(tap_req(0, -16'sd32768, 1'b0));
        enqueue(tap_req(1, 16'sd32767, 1'b1));      // last flag on a tap load
        enqueue(tap_req(2, -16'sd32768, 1'b0));
        enqueue(tap_req(63, 16'sd1234, 1'b0));      // out-of-range index, ignored
        enqueue(tap_req(62, 16'sd32767, 1'b0));     // highest index, unused at 3 taps
        enqueue(sample_req(16'sd32767, 1'b0));
        enqueue(sample_req(-16'sd32768, 1'b0));
        enqueue(sample_req(16'sd32767, 1'b0));
        enqueue(sample_req(-16'sd32768, 1'b1));
        // one-sample signal: only the flush yields the output
        enqueue(sample_req(-16'sd32768, 1'b1));
        // kernel change in mid-signal
        enqueue(sample_req(16'sd7, 1'b0));
        enqueue(sample_req(-16'sd1, 1'b0));
        enqueue(tap_req(1, -16'sd1, 1'b0));
        enqueue(sample_req(16'sd8, 1'b0));
        enqueue(sample_req(-16'sd3, 1'b1));
        settle();

        // zero tap count: every output is zero, one per sample
        set_tap_count(0);
        enqueue(sample_req(16'sd100, 1'b0));
        enqueue(sample_req(-16'sd100, 1'b0));
        enqueue(sample_req(16'sd32767, 1'b1));
        settle();

        // random phases over several tap counts, extremes included
        set_tap_count(63);
        queue_random_phase(15, 63);
        settle();
        set_tap_count(1);
        queue_random_phase(15, 1);
        settle();
        set_tap_count(2);
        queue_random_phase(15, 2);
        settle();
        set_tap_count(62);
        queue_random_phase(15, 62);
        settle();
        set_tap_count(2 * $urandom_range(1, 7) + 1);
        queue_random_phase(15, taps_in_use);
        settle();
        set_tap_count($urandom_range(0, 63));
        queue_random_phase(15, taps_in_use);
        settle();

        // closing phase without idling on either side
        set_tap_count(7);
        quiet_tail = 1'b1;
        queue_random_phase(15, 7);
        settle();

        if (mismatches == 0 && expected_outputs.size() == 0) begin
            $display("centered_fir_convolution_top verification clean");
        end else begin
            $display("centered_fir_convolution_top verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("centered_fir_convolution_top verification failed");
        $finish;
    end

endmodule
